// ----- sv/vcd_pkg.sv -----
// ----------------------------------------------------------------------------
// vcd_pkg
// Shared types and constants for the video coefficient dequantizer.
// ----------------------------------------------------------------------------
package vcd_pkg;

    localparam logic [1:0] MODE_H263_INTRA  = 2'd0;
    localparam logic [1:0] MODE_H263_INTER  = 2'd1;
    localparam logic [1:0] MODE_MPEG2_INTER = 2'd2;

    localparam logic [1:0] REG_MODE            = 2'd0;
    localparam logic [1:0] REG_ADVANCED_INTRA  = 2'd1;
    localparam logic [1:0] REG_LUMA_DC_SCALE   = 2'd2;
    localparam logic [1:0] REG_CHROMA_DC_SCALE = 2'd3;

    localparam logic [5:0] LAST_POS      = 6'd63;
    localparam logic [3:0] LUMA_BLOCKS   = 4'd4;
    localparam logic [5:0] DC_SCALE_RST  = 6'd8;

    // one classified word handed from front to back
    typedef struct packed {
        logic        is_mpeg;
        logic        neg;
        logic [5:0]  pos;
        logic [16:0] mul_a;
        logic [14:0] mul_b;
        logic [15:0] adj;
    } vcd_entry_t;

endpackage

// ----- sv/vcd_front.sv -----
// ----------------------------------------------------------------------------
// vcd_front
// Configuration registers and classification of each incoming word into
// multiplier operands, a signed rounding adjust and flags for the back end.
// ----------------------------------------------------------------------------
module vcd_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write_en,
    input  logic [1:0]          cfg_index,
    input  logic [5:0]          cfg_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic signed [15:0]  coef_in,
    input  logic [5:0]          position,
    input  logic [6:0]          qscale,
    input  logic [7:0]          weight,
    input  logic [5:0]          last_position,
    input  logic                ac_predicted,
    input  logic [3:0]          block_index,
    output logic                q_valid,
    input  logic                q_ready,
    output vcd_pkg::vcd_entry_t q_data
);

    logic [1:0]  mode_reg;
    logic        adv_intra_reg;
    logic [5:0]  luma_dc_reg;
    logic [5:0]  chroma_dc_reg;

    logic [15:0] lvl;
    logic        neg;
    logic        zero;
    logic [15:0] mag;
    logic [15:0] offset;
    logic [15:0] h263_adj;
    logic [15:0] intra_adj;
    logic [5:0]  last_eff;
    logic [5:0]  dc_scale;
    logic [14:0] qw;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= vcd_pkg::MODE_H263_INTRA;
            adv_intra_reg <= 1'b0;
            luma_dc_reg   <= vcd_pkg::DC_SCALE_RST;
            chroma_dc_reg <= vcd_pkg::DC_SCALE_RST;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                vcd_pkg::REG_MODE:            mode_reg      <= cfg_data[1:0];
                vcd_pkg::REG_ADVANCED_INTRA:  adv_intra_reg <= cfg_data[0];
                vcd_pkg::REG_LUMA_DC_SCALE:   luma_dc_reg   <= cfg_data;
                vcd_pkg::REG_CHROMA_DC_SCALE: chroma_dc_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign lvl       = $unsigned(coef_in);
    assign neg       = lvl[15];
    assign zero      = (lvl == 16'd0);
    assign mag       = neg ? (16'd0 - lvl) : lvl;
    // (q-1)|1 on signed values: q of zero gives -1
    assign offset    = ({9'd0, qscale} - 16'd1) | 16'd1;
    assign h263_adj  = zero ? 16'd0 : (neg ? (16'd0 - offset) : offset);
    assign intra_adj = adv_intra_reg ? 16'd0 : h263_adj;
    assign last_eff  = ac_predicted ? vcd_pkg::LAST_POS : last_position;
    assign dc_scale  = (block_index < vcd_pkg::LUMA_BLOCKS) ? luma_dc_reg : chroma_dc_reg;
    assign qw        = 15'({8'd0, qscale} * {7'd0, weight});

    always_comb
    begin
        q_data.is_mpeg = 1'b0;
        q_data.neg     = neg;
        q_data.pos     = position;
        q_data.mul_a   = {1'b0, lvl};
        q_data.mul_b   = 15'd1;
        q_data.adj     = 16'd0;
        case (mode_reg)
            vcd_pkg::MODE_H263_INTRA:
            begin
                if (position == 6'd0)
                begin
                    if (!adv_intra_reg)
                        q_data.mul_b = {9'd0, dc_scale};
                end
                else if (position <= last_eff)
                begin
                    q_data.mul_b = {7'd0, qscale, 1'b0};
                    q_data.adj   = intra_adj;
                end
            end
            vcd_pkg::MODE_H263_INTER:
            begin
                if (position <= last_position)
                begin
                    q_data.mul_b = {7'd0, qscale, 1'b0};
                    q_data.adj   = h263_adj;
                end
            end
            vcd_pkg::MODE_MPEG2_INTER:
            begin
                q_data.is_mpeg = 1'b1;
                q_data.mul_a   = zero ? 17'd0 : {mag, 1'b1};
                q_data.mul_b   = qw;
            end
            default: ;
        endcase
    end

    assign q_valid  = in_valid;
    assign in_ready = q_ready;

endmodule

// ----- sv/vcd_queue.sv -----
// ----------------------------------------------------------------------------
// vcd_queue
// Small FIFO of classified words between the front and the back end.
// ----------------------------------------------------------------------------
module vcd_queue #(
    parameter int DEPTH = 4
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          wr_valid,
    output logic                          wr_ready,
    input  vcd_pkg::vcd_entry_t           wr_data,
    output logic                          rd_valid,
    input  logic                          rd_ready,
    output vcd_pkg::vcd_entry_t           rd_data,
    output logic [$clog2(DEPTH+1)-1:0]    count
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    vcd_pkg::vcd_entry_t slots_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg;
    logic [AW-1:0] wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg;
    logic [AW-1:0] rd_ptr_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          push;
    logic          pop;

    assign wr_ready = (count_reg != CW'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;
    assign rd_data  = slots_reg[rd_ptr_reg];
    assign count    = count_reg;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        if (push && !pop)
            count_next = count_reg + CW'(1);
        else if (pop && !push)
            count_next = count_reg - CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slots_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

// ----- sv/vcd_back.sv -----
// ----------------------------------------------------------------------------
// vcd_back
// Multiply stage, then rounding adjust, sign restore and MPEG-2 mismatch
// control into the output register.
// ----------------------------------------------------------------------------
module vcd_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  vcd_pkg::vcd_entry_t  in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic signed [15:0]   coef_out,
    output logic [5:0]           position_out,
    output logic                 block_end,
    output logic                 parity
);

    logic        s1_valid_reg;
    logic        s1_is_mpeg_reg;
    logic        s1_neg_reg;
    logic [5:0]  s1_pos_reg;
    logic [15:0] s1_adj_reg;
    logic [31:0] s1_prod_reg;

    logic        out_valid_reg;
    logic [15:0] coef_reg;
    logic [15:0] coef_next;
    logic [5:0]  pos_reg;
    logic        parity_reg;
    logic        parity_next;

    logic        out_free;
    logic        s1_load;
    logic        s2_load;
    logic [31:0] prod;
    logic [15:0] m;
    logic        p_new;
    logic        last;

    assign out_free = !out_valid_reg || out_ready;
    assign s2_load  = s1_valid_reg && out_free;
    assign in_ready = !s1_valid_reg || out_free;
    assign s1_load  = in_valid && in_ready;
    assign prod     = {15'd0, in_data.mul_a} * {17'd0, in_data.mul_b};

    assign m     = s1_prod_reg[19:4];
    assign p_new = parity_reg ^ m[0];
    assign last  = (s1_pos_reg == vcd_pkg::LAST_POS);

    always_comb
    begin
        parity_next = parity_reg;
        if (s1_is_mpeg_reg)
        begin
            coef_next   = s1_neg_reg ? (16'd0 - m) : m;
            parity_next = p_new;
            if (last)
                coef_next[0] = coef_next[0] ^ p_new;
        end
        else
        begin
            coef_next = s1_prod_reg[15:0] + s1_adj_reg;
        end
        if (last)
            parity_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            parity_reg    <= 1'b1;
        end
        else
        begin
            if (in_ready)
                s1_valid_reg <= in_valid;
            if (out_free)
                out_valid_reg <= s1_valid_reg;
            if (s2_load)
                parity_reg <= parity_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_is_mpeg_reg <= in_data.is_mpeg;
            s1_neg_reg     <= in_data.neg;
            s1_pos_reg     <= in_data.pos;
            s1_adj_reg     <= in_data.adj;
            s1_prod_reg    <= prod;
        end
        if (s2_load)
        begin
            coef_reg <= coef_next;
            pos_reg  <= s1_pos_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign coef_out     = $signed(coef_reg);
    assign position_out = pos_reg;
    assign block_end    = (pos_reg == vcd_pkg::LAST_POS);
    assign parity       = parity_reg;

endmodule

// ----- sv/video_coefficient_dequantizer_core.sv -----
// ----------------------------------------------------------------------------
// video_coefficient_dequantizer_core
// H.263 / MPEG-2 inverse quantization of a coefficient stream.
// ----------------------------------------------------------------------------
// One coefficient word is accepted per clock and one result word is produced
// per clock in steady state, while neither side stalls; each word passes
// through the queue, the multiply stage and the output register. The rate is
// set by the 17x15 multiplier in the back end, which takes one word per cycle
// unless the output stalls.
// The front end classifies each word by mode and position into multiplier
// operands; a queue of QUEUE_DEPTH words lets front and back stall apart.
// The user must write configuration only while the block holds no words; the block does not enforce this.
module video_coefficient_dequantizer_core #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write_en,
    input  logic [1:0]         cfg_index,
    input  logic [5:0]         cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [15:0] coef_in,
    input  logic [5:0]         position,
    input  logic [6:0]         qscale,
    input  logic [7:0]         weight,
    input  logic [5:0]         last_position,
    input  logic               ac_predicted,
    input  logic [3:0]         block_index,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] coef_out,
    output logic [5:0]         position_out,
    output logic               block_end
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    vcd_pkg::vcd_entry_t fq_data;
    vcd_pkg::vcd_entry_t qb_data;
    logic                fq_valid;
    logic                fq_ready;
    logic                qb_valid;
    logic                qb_ready;
    logic [CW-1:0]       q_count;
    logic                parity;

    vcd_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write_en  (cfg_write_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .coef_in       (coef_in),
        .position      (position),
        .qscale        (qscale),
        .weight        (weight),
        .last_position (last_position),
        .ac_predicted  (ac_predicted),
        .block_index   (block_index),
        .q_valid       (fq_valid),
        .q_ready       (fq_ready),
        .q_data        (fq_data)
    );

    vcd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (fq_valid),
        .wr_ready (fq_ready),
        .wr_data  (fq_data),
        .rd_valid (qb_valid),
        .rd_ready (qb_ready),
        .rd_data  (qb_data),
        .count    (q_count)
    );

    vcd_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (qb_valid),
        .in_ready     (qb_ready),
        .in_data      (qb_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .coef_out     (coef_out),
        .position_out (position_out),
        .block_end    (block_end),
        .parity       (parity)
    );

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_count <= CW'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_full_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (q_count == CW'(QUEUE_DEPTH)) |-> !in_ready)
        else $error("input taken while queue full");

    a_block_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (block_end == (position_out == vcd_pkg::LAST_POS)))
        else $error("block_end does not match position");

    a_parity_reset: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && block_end) |=> (parity || out_valid))
        else $error("parity not restored after end of block");

endmodule

// ----- tb/sv/tb_video_coefficient_dequantizer_core.sv -----
// ----------------------------------------------------------------------------
// tb_video_coefficient_dequantizer_core
// Self-checking bench for the H.263 / MPEG-2 coefficient dequantizer.
// A short table of directed words is followed by random blocks of 64
// coefficients and stray noise words, run under several register settings.
// Each accepted word is predicted in order, including the MPEG-2 mismatch
// parity. Each result word is compared field by field. Both sides stall in
// random bursts, and one long output hold backs the block up to its input.
// ----------------------------------------------------------------------------
module tb_video_coefficient_dequantizer_core;

    localparam logic [1:0] MODE_UNUSED = 2'd3;

    typedef struct {
        logic signed [15:0] level;
        logic [5:0]         pos;
        logic [6:0]         qscale;
        logic [7:0]         weight;
        logic [5:0]         last_pos;
        logic               ac_pred;
        logic [3:0]         blk;
    } coef_word_t;

    typedef struct {
        logic [15:0] coef;
        logic [5:0]  pos;
        logic        blk_end;
    } dequant_word_t;

    typedef struct packed {
        logic [1:0]  mode;
        logic        adv;
        logic [5:0]  luma;
        logic [5:0]  chroma;
        logic [15:0] level;
        logic [5:0]  pos;
        logic [6:0]  qscale;
        logic [7:0]  weight;
        logic [5:0]  last_pos;
        logic        ac_pred;
        logic [3:0]  blk;
        logic        typed;
        logic [15:0] coef_exp;
    } dir_row_t;

    // mode adv luma chroma level | pos q w last acp blk | typed expected
    dir_row_t dir_tab [0:24] = '{
        '{vcd_pkg::MODE_H263_INTRA, 1'b0, 6'd8, 6'd8, 16'd5,
          6'd0, 7'd1, 8'd0, 6'd0, 1'b0, 4'd0, 1'b1, 16'd40},
        '{vcd_pkg::MODE_H263_INTRA, 1'b0, 6'd8, 6'd8, -16'sd3,
          6'd0, 7'd1, 8'd0, 6'd0, 1'b0, 4'd5, 1'b1, 16'hFFE8},
        '{vcd_pkg::MODE_H263_INTRA, 1'b0, 6'd8, 6'd8, 16'd0,
          6'd5, 7'd10, 8'd0, 6'd10, 1'b0, 4'd0, 1'b1, 16'd0},
        '{vcd_pkg::MODE_H263_INTRA, 1'b0, 6'd8, 6'd8, 16'd2,
          6'd5, 7'd3, 8'd0, 6'd10, 1'b0, 4'd0, 1'b1, 16'd15},
        '{vcd_pkg::MODE_H263_INTRA, 1'b0, 6'd8, 6'd8, -16'sd2,
          6'd5, 7'd3, 8'd0, 6'd10, 1'b0, 4'd0, 1'b1, 16'hFFF1},
        '{vcd_pkg::MODE_H263_INTRA, 1'b0, 6'd8, 6'd8, 16'd7,
          6'd20, 7'd3, 8'd0, 6'd10, 1'b0, 4'd0, 1'b1, 16'd7},
        '{vcd_pkg::MODE_H263_INTRA, 1'b0, 6'd8, 6'd8, 16'd7,
          6'd20, 7'd1, 8'd0, 6'd10, 1'b1, 4'd0, 1'b1, 16'd15},
        '{vcd_pkg::MODE_H263_INTRA, 1'b0, 6'd8, 6'd8, 16'h7FFF,
          6'd1, 7'd127, 8'd0, 6'd63, 1'b0, 4'd0, 1'b1, 16'hFF81},
        '{vcd_pkg::MODE_H263_INTRA, 1'b0, 6'd8, 6'd8, 16'h8000,
          6'd63, 7'd127, 8'd0, 6'd0, 1'b0, 4'd15, 1'b1, 16'h8000},
        '{vcd_pkg::MODE_H263_INTRA, 1'b1, 6'd63, 6'd1, 16'd100,
          6'd0, 7'd1, 8'd0, 6'd0, 1'b0, 4'd3, 1'b1, 16'd100},
        '{vcd_pkg::MODE_H263_INTRA, 1'b1, 6'd63, 6'd1, 16'd3,
          6'd4, 7'd5, 8'd0, 6'd63, 1'b0, 4'd0, 1'b1, 16'd30},
        '{vcd_pkg::MODE_H263_INTRA, 1'b0, 6'd63, 6'd1, 16'd1000,
          6'd0, 7'd1, 8'd0, 6'd0, 1'b0, 4'd3, 1'b1, 16'hF618},
        '{vcd_pkg::MODE_H263_INTRA, 1'b0, 6'd63, 6'd1, -16'sd1000,
          6'd0, 7'd1, 8'd0, 6'd0, 1'b0, 4'd4, 1'b1, 16'hFC18},
        '{vcd_pkg::MODE_H263_INTRA, 1'b0, 6'd63, 6'd1, 16'd1,
          6'd2, 7'd0, 8'd0, 6'd63, 1'b0, 4'd0, 1'b1, 16'hFFFF},
        '{vcd_pkg::MODE_H263_INTER, 1'b1, 6'd63, 6'd1, 16'd4,
          6'd0, 7'd2, 8'd0, 6'd0, 1'b0, 4'd0, 1'b1, 16'd17},
        '{vcd_pkg::MODE_H263_INTER, 1'b1, 6'd63, 6'd1, 16'd4,
          6'd1, 7'd2, 8'd0, 6'd0, 1'b0, 4'd0, 1'b1, 16'd4},
        '{vcd_pkg::MODE_H263_INTER, 1'b1, 6'd63, 6'd1, -16'sd1,
          6'd63, 7'd127, 8'd0, 6'd63, 1'b0, 4'd0, 1'b1, 16'hFE83},
        '{vcd_pkg::MODE_MPEG2_INTER, 1'b0, 6'd63, 6'd1, 16'd0,
          6'd0, 7'd5, 8'd16, 6'd0, 1'b0, 4'd0, 1'b1, 16'd0},
        '{vcd_pkg::MODE_MPEG2_INTER, 1'b0, 6'd63, 6'd1, 16'd1,
          6'd1, 7'd1, 8'd16, 6'd0, 1'b0, 4'd0, 1'b1, 16'd3},
        '{vcd_pkg::MODE_MPEG2_INTER, 1'b0, 6'd63, 6'd1, -16'sd1,
          6'd2, 7'd2, 8'd8, 6'd0, 1'b0, 4'd0, 1'b1, 16'hFFFD},
        '{vcd_pkg::MODE_MPEG2_INTER, 1'b0, 6'd63, 6'd1, 16'h7FFF,
          6'd3, 7'd127, 8'd255, 6'd0, 1'b0, 4'd0, 1'b0, 16'd0},
        '{vcd_pkg::MODE_MPEG2_INTER, 1'b0, 6'd63, 6'd1, 16'h8000,
          6'd4, 7'd127, 8'd255, 6'd0, 1'b0, 4'd0, 1'b0, 16'd0},
        '{vcd_pkg::MODE_MPEG2_INTER, 1'b0, 6'd63, 6'd1, 16'd5,
          6'd63, 7'd1, 8'd0, 6'd0, 1'b0, 4'd0, 1'b0, 16'd0},
        '{MODE_UNUSED, 1'b0, 6'd63, 6'd1, 16'd1234,
          6'd63, 7'd9, 8'd9, 6'd0, 1'b0, 4'd0, 1'b1, 16'd1234},
        '{MODE_UNUSED, 1'b0, 6'd63, 6'd1, -16'sd5,
          6'd0, 7'd9, 8'd9, 6'd0, 1'b0, 4'd0, 1'b1, 16'hFFFB}
    };

    logic               clk;
    logic               rst_n;
    logic               cfg_write_en;
    logic [1:0]         cfg_index;
    logic [5:0]         cfg_data;
    logic               in_valid;
    logic               in_ready;
    logic signed [15:0] coef_in;
    logic [5:0]         position;
    logic [6:0]         qscale;
    logic [7:0]         weight;
    logic [5:0]         last_position;
    logic               ac_predicted;
    logic [3:0]         block_index;
    logic               out_valid;
    logic               out_ready;
    logic signed [15:0] coef_out;
    logic [5:0]         position_out;
    logic               block_end;

    logic [1:0] cfg_mode;
    logic       cfg_adv;
    logic [5:0] cfg_luma;
    logic [5:0] cfg_chroma;
    logic       sum_par;

    dequant_word_t pending_q[$];
    int            mismatches;
    int            words_sent;
    int            phase;
    bit            idle_on;
    bit            long_hold_req;
    dir_row_t      row;
    coef_word_t    wd;
    int            r;

    video_coefficient_dequantizer_core u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write_en  (cfg_write_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .coef_in       (coef_in),
        .position      (position),
        .qscale        (qscale),
        .weight        (weight),
        .last_position (last_position),
        .ac_predicted  (ac_predicted),
        .block_index   (block_index),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .coef_out      (coef_out),
        .position_out  (position_out),
        .block_end     (block_end)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    function automatic dequant_word_t dequant_word(coef_word_t w);
        dequant_word_t e;
        int            lvl;
        int            q;
        int            bias;
        int            res;
        int            sc;
        longint        mag;
        longint        m;
        logic [5:0]    last;
        lvl  = int'(w.level);
        q    = int'(w.qscale);
        bias = (q - 1) | 1;
        res  = lvl;
        last = w.last_pos;
        case (cfg_mode)
            vcd_pkg::MODE_H263_INTRA:
            begin
                if (w.ac_pred)
                    last = vcd_pkg::LAST_POS;
                if (cfg_adv)
                    bias = 0;
                if (w.pos == 6'd0)
                begin
                    if (!cfg_adv)
                    begin
                        sc  = int'((w.blk < vcd_pkg::LUMA_BLOCKS) ? cfg_luma : cfg_chroma);
                        res = lvl * sc;
                    end
                end
                else if (w.pos <= last && lvl != 0)
                    res = lvl * q * 2 + ((lvl < 0) ? -bias : bias);
            end
            vcd_pkg::MODE_H263_INTER:
            begin
                if (w.pos <= last && lvl != 0)
                    res = lvl * q * 2 + ((lvl < 0) ? -bias : bias);
            end
            vcd_pkg::MODE_MPEG2_INTER:
            begin
                if (lvl != 0)
                begin
                    mag = longint'((lvl < 0) ? -lvl : lvl);
                    m   = ((2 * mag + 1) * longint'(q) * longint'(w.weight)) >> 4;
                    res = int'((lvl < 0) ? -m : m);
                end
                sum_par = sum_par ^ res[0];
                if (w.pos == vcd_pkg::LAST_POS)
                    res[0] = res[0] ^ sum_par;
            end
            default: ;
        endcase
        if (w.pos == vcd_pkg::LAST_POS)
            sum_par = 1'b1;
        e.coef    = res[15:0];
        e.pos     = w.pos;
        e.blk_end = (w.pos == vcd_pkg::LAST_POS);
        return e;
    endfunction

    function automatic logic signed [15:0] pick_level();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return 16'sd0;
            4, 5, 6:    return 16'($urandom_range(0, 16) - 8);
            7:          return 16'($urandom_range(0, 600) - 300);
            8:
            begin
                case ($urandom_range(0, 3))
                    0:       return 16'sh7FFF;
                    1:       return 16'sh8000;
                    2:       return 16'sh0001;
                    default: return 16'shFFFF;
                endcase
            end
            default:    return 16'($urandom);
        endcase
    endfunction

    function automatic logic [5:0] pick_scale();
        case ($urandom_range(0, 7))
            0:       return 6'd1;
            1:       return 6'd63;
            2:       return 6'd0;
            default: return 6'($urandom_range(1, 63));
        endcase
    endfunction

    task automatic note_mismatch(string msg);
        if (mismatches < 10)
            $display("%s", msg);
        mismatches++;
    endtask

    // drop valid, then wait out all pending words plus pipeline depth
    task automatic settle();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending_q.size() != 0)
            @(posedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [5:0] data);
        @(negedge clk);
        cfg_write_en = 1'b1;
        cfg_index    = idx;
        cfg_data     = data;
        @(negedge clk);
        cfg_write_en = 1'b0;
        case (idx)
            vcd_pkg::REG_MODE:            cfg_mode   = data[1:0];
            vcd_pkg::REG_ADVANCED_INTRA:  cfg_adv    = data[0];
            vcd_pkg::REG_LUMA_DC_SCALE:   cfg_luma   = data;
            vcd_pkg::REG_CHROMA_DC_SCALE: cfg_chroma = data;
            default: ;
        endcase
    endtask

    task automatic set_dequant_config(logic [5:0] mode_d, logic [5:0] adv_d,
                                      logic [5:0] luma_d, logic [5:0] chroma_d);
        settle();
        write_reg(vcd_pkg::REG_MODE, mode_d);
        write_reg(vcd_pkg::REG_ADVANCED_INTRA, adv_d);
        write_reg(vcd_pkg::REG_LUMA_DC_SCALE, luma_d);
        write_reg(vcd_pkg::REG_CHROMA_DC_SCALE, chroma_d);
    endtask

    task automatic send_word(coef_word_t w, logic typed, logic [15:0] coef_exp);
        dequant_word_t e;
        int            gap;
        @(negedge clk);
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 12);
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        coef_in       = w.level;
        position      = w.pos;
        qscale        = w.qscale;
        weight        = w.weight;
        last_position = w.last_pos;
        ac_predicted  = w.ac_pred;
        block_index   = w.blk;
        in_valid      = 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        e = dequant_word(w);
        if (typed)
            e.coef = coef_exp;
        pending_q.push_back(e);
        words_sent++;
    endtask

    // one 8x8 block in raster order; now and then a scrambled one
    task automatic send_block();
        coef_word_t w;
        logic       broken;
        int         sel;
        sel = $urandom_range(0, 19);
        w.qscale   = (sel == 0) ? 7'd0 : (sel == 1) ? 7'd1 : (sel == 2) ? 7'd127 :
                     7'($urandom_range(1, 127));
        w.last_pos = 6'($urandom_range(0, 63));
        w.ac_pred  = 1'($urandom_range(0, 1));
        w.blk      = 4'($urandom_range(0, 15));
        broken     = ($urandom_range(0, 9) == 0);
        for (int p = 0; p < 64; p++)
        begin
            w.level  = pick_level();
            w.pos    = (broken && $urandom_range(0, 5) == 0) ? 6'($urandom_range(0, 63)) :
                       6'(p);
            w.weight = 8'($urandom_range(0, 255));
            send_word(w, 1'b0, 16'd0);
        end
    endtask

    always @(posedge clk)
    begin : check_out
        dequant_word_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_q.size() == 0)
                note_mismatch($sformatf("unexpected word: coef_out %h position_out %0d",
                                        coef_out, position_out));
            else
            begin
                e = pending_q.pop_front();
                if (coef_out !== e.coef || position_out !== e.pos || block_end !== e.blk_end)
                    note_mismatch($sformatf(
                        "word mismatch: coef_out %h/%h position_out %0d/%0d block_end %0d/%0d",
                        e.coef, coef_out, e.pos, position_out, e.blk_end, block_end));
            end
        end
    end

    // output side: random stalls, plus one long hold on request
    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (long_hold_req)
            begin
                out_ready = 1'b0;
                repeat (300) @(negedge clk);
                long_hold_req = 1'b0;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                out_ready = 1'b0;
                repeat ($urandom_range(0, 11)) @(negedge clk);
            end
            else
                out_ready = 1'b1;
        end
    end

    initial
    begin
        #2_000_000;
        $display("video_coefficient_dequantizer_core: mismatch");
        $finish;
    end

    initial
    begin
        rst_n         = 1'b0;
        cfg_write_en  = 1'b0;
        cfg_index     = vcd_pkg::REG_MODE;
        cfg_data      = 6'd0;
        in_valid      = 1'b0;
        coef_in       = 16'sd0;
        position      = 6'd0;
        qscale        = 7'd0;
        weight        = 8'd0;
        last_position = 6'd0;
        ac_predicted  = 1'b0;
        block_index   = 4'd0;
        cfg_mode      = vcd_pkg::MODE_H263_INTRA;
        cfg_adv       = 1'b0;
        cfg_luma      = vcd_pkg::DC_SCALE_RST;
        cfg_chroma    = vcd_pkg::DC_SCALE_RST;
        sum_par       = 1'b1;
        mismatches    = 0;
        words_sent    = 0;
        phase         = 0;
        idle_on       = 1'b1;
        long_hold_req = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int i = 0; i < 25; i++)
        begin
            row = dir_tab[i];
            if (row.mode != cfg_mode || row.adv != cfg_adv || row.luma != cfg_luma ||
                row.chroma != cfg_chroma)
                set_dequant_config({4'd0, row.mode}, {5'd0, row.adv}, row.luma, row.chroma);
            wd.level    = row.level;
            wd.pos      = row.pos;
            wd.qscale   = row.qscale;
            wd.weight   = row.weight;
            wd.last_pos = row.last_pos;
            wd.ac_pred  = row.ac_pred;
            wd.blk      = row.blk;
            send_word(wd, row.typed, row.coef_exp);
        end

        while (words_sent < 1325)
        begin
            idle_on = (words_sent < 1100) && ($urandom_range(0, 3) != 0);
            r = $urandom_range(0, 9);
            // upper data bits are don't-care for the narrow registers
            set_dequant_config({4'($urandom), (r == 0) ? MODE_UNUSED :
                                2'($urandom_range(0, 2))},
                               {5'($urandom), 1'($urandom)}, pick_scale(), pick_scale());
            if (phase == 2)
                long_hold_req = 1'b1;
            repeat ($urandom_range(1, 2)) send_block();
            repeat ($urandom_range(0, 6))
            begin
                wd.level    = pick_level();
                wd.pos      = 6'($urandom_range(0, 63));
                wd.qscale   = 7'($urandom_range(0, 127));
                wd.weight   = 8'($urandom_range(0, 255));
                wd.last_pos = 6'($urandom_range(0, 63));
                wd.ac_pred  = 1'($urandom_range(0, 1));
                wd.blk      = 4'($urandom_range(0, 15));
                send_word(wd, 1'b0, 16'd0);
            end
            phase++;
        end

        @(negedge clk);
        in_valid = 1'b0;
        while (pending_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("video_coefficient_dequantizer_core: match");
        else
            $display("video_coefficient_dequantizer_core: mismatch");
        $finish;
    end

endmodule
